@@ rtl/mrm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes for the 4x4 Q16.16 row multiplier.
// Used by every module of the block; depends on nothing.
package mrm_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ROW_W     = 2;
	localparam int NUM_ELEMS = 4;
	localparam int DIM_DEF   = 4;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MUL  = 1'b1;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] elem_t;

	// pipeline advance enables, one per stage
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_out;
	} mrm_adv_t;

	// width of the full-precision column sum for a lane with nl products
	function automatic int sum_width(input int nl);
		int np;
		np = (nl + 1) >> 1;
		return PAIR_W + $clog2(np);
	endfunction

endpackage

@@ rtl/mrm_lane.sv @@
`timescale 1ns / 1ps
// One result column: NL parallel 32x32 products, then a registered adder tree.
// Depends on mrm_pkg.
module mrm_lane #(
	parameter int NL    = mrm_pkg::DIM_DEF,
	parameter int SUM_W = mrm_pkg::sum_width(mrm_pkg::DIM_DEF)
) (
	input  logic                  clk,
	input  mrm_pkg::mrm_adv_t     adv,
	input  mrm_pkg::elem_t        lhs [NL],
	input  mrm_pkg::elem_t        col [NL],
	output logic signed [SUM_W-1:0] sum_s3
);

	localparam int NP = (NL + 1) / 2;

	logic signed [mrm_pkg::PROD_W-1:0] prod_s1 [NL];
	logic signed [mrm_pkg::PAIR_W-1:0] pair_s2 [NP];
	logic signed [mrm_pkg::PAIR_W-1:0] pair_d  [NP];
	logic signed [SUM_W-1:0]           sum_d;

	// stage 1: products
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			for (int k = 0; k < NL; k++) begin
				prod_s1[k] <= mrm_pkg::PROD_W'(lhs[k]) * mrm_pkg::PROD_W'(col[k]);
			end
		end
	end

	// stage 2: pairwise sums
	for (genvar p = 0; p < NP; p++) begin : g_pair
		if (2 * p + 1 < NL) begin : g_two
			assign pair_d[p] = mrm_pkg::PAIR_W'(prod_s1[2*p]) +
			                   mrm_pkg::PAIR_W'(prod_s1[2*p+1]);
		end else begin : g_one
			assign pair_d[p] = mrm_pkg::PAIR_W'(prod_s1[2*p]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			pair_s2 <= pair_d;
		end
	end

	// stage 3: column total
	always_comb begin
		sum_d = '0;
		for (int p = 0; p < NP; p++) begin
			sum_d = sum_d + SUM_W'(pair_s2[p]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			sum_s3 <= sum_d;
		end
	end

endmodule

@@ rtl/mrm_merge.sv @@
`timescale 1ns / 1ps
// Output stage: shift each lane total down to Q16.16, saturate, and register the row.
// Depends on mrm_pkg.
module mrm_merge #(
	parameter int NL    = mrm_pkg::DIM_DEF,
	parameter int SUM_W = mrm_pkg::sum_width(mrm_pkg::DIM_DEF)
) (
	input  logic                          clk,
	input  mrm_pkg::mrm_adv_t             adv,
	input  logic [mrm_pkg::ROW_W-1:0]     row_s3,
	input  logic signed [SUM_W-1:0]       sum_s3 [NL],
	output logic [mrm_pkg::ROW_W-1:0]     out_row_q,
	output mrm_pkg::elem_t                res_q [mrm_pkg::NUM_ELEMS]
);

	localparam int TOP_LO = mrm_pkg::FRAC_W + mrm_pkg::DATA_W - 1;

	mrm_pkg::elem_t res_d [mrm_pkg::NUM_ELEMS];

	function automatic mrm_pkg::elem_t shift_sat(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-1:TOP_LO] upper;
		upper = s[SUM_W-1:TOP_LO];
		if ((&upper) || !(|upper)) begin
			return s[TOP_LO:mrm_pkg::FRAC_W];
		end
		return s[SUM_W-1] ? mrm_pkg::SAT_MIN : mrm_pkg::SAT_MAX;
	endfunction

	// columns beyond the matrix size read as zero
	always_comb begin
		for (int x = 0; x < mrm_pkg::NUM_ELEMS; x++) begin
			res_d[x] = '0;
		end
		for (int x = 0; x < NL; x++) begin
			res_d[x] = shift_sat(sum_s3[x]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_out) begin
			out_row_q <= row_s3;
			res_q     <= res_d;
		end
	end

endmodule

@@ rtl/matrix4_row_multiply_top.sv @@
`timescale 1ns / 1ps
// Top level of the Q16.16 row multiplier: right-hand matrix store, lanes, output stage.
// Depends on mrm_pkg, mrm_lane and mrm_merge.
//
// Load beats (action ACT_LOAD) write one row of the right-hand matrix into a register
// store that reset clears to zero; they take effect for any multiply beat accepted on
// the next cycle and produce no result. Multiply beats (action ACT_MUL) carry one
// left-hand row; each is answered by one result row with res_x = sat32(floor(sum_k
// lhs[k]*rhs[k][x] / 2^16)), out_row echoing row_index. One beat of either kind is
// accepted every cycle while stall is low. On the way to res_valid, a multiply beat goes
// through the bank of 32x32 multipliers (one per lane and term), which works on the beat
// in its accepting cycle, then the registered adder tree of each column lane (pairwise
// sums, then column total), then shift, saturate and the output register. Each stage
// moves on its own, so bubbles are squeezed out and stall only rises once all four
// stages hold work behind a stalled result. Loads of a row at or beyond DIM are
// dropped; columns at or beyond DIM read as zero.
module matrix4_row_multiply_top #(
	parameter int DIM = mrm_pkg::DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        valid,
	output logic                        stall,
	input  logic                        action,
	input  logic [mrm_pkg::ROW_W-1:0]   row_index,
	input  mrm_pkg::elem_t              elem_0,
	input  mrm_pkg::elem_t              elem_1,
	input  mrm_pkg::elem_t              elem_2,
	input  mrm_pkg::elem_t              elem_3,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [mrm_pkg::ROW_W-1:0]   out_row,
	output mrm_pkg::elem_t              res_0,
	output mrm_pkg::elem_t              res_1,
	output mrm_pkg::elem_t              res_2,
	output mrm_pkg::elem_t              res_3
);

	// only four elements arrive per beat, so lanes and terms stop at four
	localparam int NL    = (DIM < mrm_pkg::NUM_ELEMS) ? DIM : mrm_pkg::NUM_ELEMS;
	localparam int SUM_W = mrm_pkg::sum_width(NL);

	mrm_pkg::elem_t    in_elem [mrm_pkg::NUM_ELEMS];
	mrm_pkg::elem_t    lhs [NL];
	mrm_pkg::elem_t    rhs_q [NL][NL];
	mrm_pkg::elem_t    res_row [mrm_pkg::NUM_ELEMS];
	logic signed [SUM_W-1:0] sum_s3 [NL];

	mrm_pkg::mrm_adv_t adv;

	logic                      v_s1, v_s2, v_s3, res_valid_q;
	logic [mrm_pkg::ROW_W-1:0] row_s1, row_s2, row_s3;
	logic                      room_o, room_3, room_2, room_1;
	logic                      accept, load_acc, take_out;

	assign in_elem = '{elem_0, elem_1, elem_2, elem_3};

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			lhs[k] = in_elem[k];
		end
	end

	// Flow control: a stage has room when empty or when it moves on this cycle.
	assign room_o   = !res_valid_q || !res_stall;
	assign room_3   = !v_s3 || room_o;
	assign room_2   = !v_s2 || room_3;
	assign room_1   = !v_s1 || room_2;
	assign stall    = !room_1;
	assign accept   = valid && room_1;
	assign load_acc = accept && (action == mrm_pkg::ACT_LOAD);
	assign take_out = res_valid_q && !res_stall;

	assign adv.en_s1  = accept && (action == mrm_pkg::ACT_MUL);
	assign adv.en_s2  = v_s1 && room_2;
	assign adv.en_s3  = v_s2 && room_3;
	assign adv.en_out = v_s3 && room_o;

	// Stage occupancy: fill on a move in, drain on a move out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv.en_s1) begin
				v_s1 <= 1'b1;
			end else if (adv.en_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv.en_s2) begin
				v_s2 <= 1'b1;
			end else if (adv.en_s3) begin
				v_s2 <= 1'b0;
			end
			if (adv.en_s3) begin
				v_s3 <= 1'b1;
			end else if (adv.en_out) begin
				v_s3 <= 1'b0;
			end
			if (adv.en_out) begin
				res_valid_q <= 1'b1;
			end else if (take_out) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Row number rides alongside the lane pipeline.
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			row_s1 <= row_index;
		end
		if (adv.en_s2) begin
			row_s2 <= row_s1;
		end
		if (adv.en_s3) begin
			row_s3 <= row_s2;
		end
	end

	// Right-hand matrix store. Rows at or beyond the lane count never match and are
	// dropped; columns at or beyond the lane count are always zero, so they are not stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NL; r++) begin
				for (int c = 0; c < NL; c++) begin
					rhs_q[r][c] <= '0;
				end
			end
		end else if (load_acc) begin
			for (int r = 0; r < NL; r++) begin
				if (row_index == mrm_pkg::ROW_W'(r)) begin
					for (int c = 0; c < NL; c++) begin
						rhs_q[r][c] <= in_elem[c];
					end
				end
			end
		end
	end

	// One lane per result column, each fed its column of the store.
	for (genvar x = 0; x < NL; x++) begin : g_lane
		mrm_pkg::elem_t col [NL];

		always_comb begin
			for (int k = 0; k < NL; k++) begin
				col[k] = rhs_q[k][x];
			end
		end

		mrm_lane #(
			.NL    (NL),
			.SUM_W (SUM_W)
		) u_lane (
			.clk    (clk),
			.adv    (adv),
			.lhs    (lhs),
			.col    (col),
			.sum_s3 (sum_s3[x])
		);
	end

	mrm_merge #(
		.NL    (NL),
		.SUM_W (SUM_W)
	) u_merge (
		.clk       (clk),
		.adv       (adv),
		.row_s3    (row_s3),
		.sum_s3    (sum_s3),
		.out_row_q (out_row),
		.res_q     (res_row)
	);

	assign res_valid = res_valid_q;
	assign res_0     = res_row[0];
	assign res_1     = res_row[1];
	assign res_2     = res_row[2];
	assign res_3     = res_row[3];

endmodule

@@ rtl/mrm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the row multiplier, bound to the top level.
// Depends on mrm_pkg and matrix4_row_multiply_top.
module mrm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        valid,
	input logic                        stall,
	input logic                        action,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [mrm_pkg::ROW_W-1:0]   out_row,
	input mrm_pkg::elem_t              res_0,
	input mrm_pkg::elem_t              res_1,
	input mrm_pkg::elem_t              res_2,
	input mrm_pkg::elem_t              res_3
);

	logic mul_beat;
	assign mul_beat = valid && !stall && (action == mrm_pkg::ACT_MUL);

	// hold a stalled result beat
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(out_row) && $stable(res_0) &&
			$stable(res_1) && $stable(res_2) && $stable(res_3))
		else $error("result payload changed while stalled");

	// an empty output register means every stage has room
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !stall)
		else $error("request stalled with output register empty");

	// with the output free and no multiply beat, the pipeline drains and stays empty
	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid && !mul_beat) ##1 (!res_valid && !mul_beat) ##1
		(!res_valid && !mul_beat) ##1 (!res_valid && !mul_beat) |=> !res_valid)
		else $error("result beat without a multiply beat");

endmodule

bind matrix4_row_multiply_top mrm_checker u_mrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (valid),
	.stall     (stall),
	.action    (action),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.out_row   (out_row),
	.res_0     (res_0),
	.res_1     (res_1),
	.res_2     (res_2),
	.res_3     (res_3)
);

@@ test/matrix4_row_multiply_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for matrix4_row_multiply_top: load and multiply beats, exact Q16.16 rows.
// Depends on mrm_pkg and the matrix4_row_multiply_top RTL only.
import mrm_pkg::*;

typedef struct packed {
	logic                 action;
	logic [ROW_W-1:0]     row;
	elem_t [NUM_ELEMS-1:0] elem;
} row_beat_t;

typedef struct packed {
	logic [ROW_W-1:0]     row;
	elem_t [NUM_ELEMS-1:0] col;
} result_row_t;

// Right-hand matrix copy plus the queue of result rows still owed by the block.
class q16_row_products;
	elem_t       rhs_rows[DIM_DEF][DIM_DEF];
	result_row_t due_rows[$];
	int          errors;

	function new();
		foreach (rhs_rows[r, c])
			rhs_rows[r][c] = '0;
		errors = 0;
	endfunction

	function int pending();
		return due_rows.size();
	endfunction

	task report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Apply a load, or work out the row a multiply beat must produce.
	function void note_beat(input row_beat_t b);
		result_row_t        want;
		logic signed [79:0] acc;
		logic signed [79:0] scaled;
		if (b.action == ACT_LOAD) begin
			if (int'(b.row) < DIM_DEF)
				for (int c = 0; c < DIM_DEF; c++)
					rhs_rows[b.row][c] = b.elem[c];
			return;
		end
		want.row = b.row;
		for (int x = 0; x < DIM_DEF; x++) begin
			acc = '0;
			for (int k = 0; k < DIM_DEF; k++)
				acc = acc + (longint'(b.elem[k]) * longint'(rhs_rows[k][x]));
			// floor division by 2^16, then clamp to the 32-bit range
			scaled = acc >>> FRAC_W;
			if (scaled[79:31] == {49{scaled[31]}})
				want.col[x] = scaled[31:0];
			else
				want.col[x] = scaled[79] ? SAT_MIN : SAT_MAX;
		end
		due_rows.push_back(want);
	endfunction

	task check_row(input result_row_t got);
		result_row_t want;
		if (due_rows.size() == 0) begin
			report_mismatch($sformatf("result row %0d with nothing pending", got.row));
			return;
		end
		want = due_rows.pop_front();
		if (got.row !== want.row)
			report_mismatch($sformatf("out_row: got %0d, expected %0d", got.row, want.row));
		for (int x = 0; x < NUM_ELEMS; x++)
			if (got.col[x] !== want.col[x])
				report_mismatch($sformatf("res_%0d row %0d: got %h, expected %h",
					x, want.row, got.col[x], want.col[x]));
	endtask
endclass

module matrix4_row_multiply_top_tb;

	localparam int    QUIET_LIMIT = 2000;
	localparam elem_t ONE         = 32'sh0001_0000;
	localparam elem_t HALF        = 32'sh0000_8000;

	logic             clk;
	logic             arst_n;
	logic             valid;
	logic             stall;
	logic             action;
	logic [ROW_W-1:0] row_index;
	elem_t            elem_0, elem_1, elem_2, elem_3;
	logic             res_valid;
	logic             res_stall;
	logic [ROW_W-1:0] out_row;
	elem_t            res_0, res_1, res_2, res_3;

	// idle bounds per side, changed between phases; a nonzero long hold is taken
	// once by the result sink at its next beat
	int tx_idle_max;
	int rx_idle_max;
	int rx_long_hold;

	q16_row_products book = new();

	matrix4_row_multiply_top #(
		.DIM(DIM_DEF)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.action    (action),
		.row_index (row_index),
		.elem_0    (elem_0),
		.elem_1    (elem_1),
		.elem_2    (elem_2),
		.elem_3    (elem_3),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_row   (out_row),
		.res_0     (res_0),
		.res_1     (res_1),
		.res_2     (res_2),
		.res_3     (res_3)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic row_beat_t make_beat(input logic act, input int row,
			input elem_t e0, input elem_t e1, input elem_t e2, input elem_t e3);
		row_beat_t b;
		b.action  = act;
		b.row     = row[ROW_W-1:0];
		b.elem[0] = e0;
		b.elem[1] = e1;
		b.elem[2] = e2;
		b.elem[3] = e3;
		return b;
	endfunction

	// Mix full-range words, small values that keep sums in range, scaled
	// magnitudes and the corner codes.
	function automatic elem_t rand_elem();
		elem_t v;
		v = elem_t'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: v = v >>> 12;
			2: v = v >>> $urandom_range(0, 31);
			default: begin
				case ($urandom_range(0, 4))
					0: v = SAT_MAX;
					1: v = SAT_MIN;
					2: v = '0;
					3: v = -32'sd1;
					default: v = ONE;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic row_beat_t rand_beat();
		row_beat_t b;
		b.action = ($urandom_range(0, 1) == 1) ? ACT_MUL : ACT_LOAD;
		b.row    = ROW_W'($urandom_range(0, 3));
		for (int k = 0; k < NUM_ELEMS; k++)
			b.elem[k] = rand_elem();
		return b;
	endfunction

	// Idle for a drawn gap, then offer the beat and hold it until accepted.
	// Returns at the accepting edge with valid still high.
	task automatic send_beat(input row_beat_t b);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid     <= 1'b1;
		action    <= b.action;
		row_index <= b.row;
		elem_0    <= b.elem[0];
		elem_1    <= b.elem[1];
		elem_2    <= b.elem[2];
		elem_3    <= b.elem[3];
		do @(posedge clk); while (stall !== 1'b0);
	endtask

	// Load all four right-hand rows: diag on the diagonal, off elsewhere.
	task automatic load_matrix(input elem_t diag, input elem_t off);
		for (int r = 0; r < DIM_DEF; r++)
			send_beat(make_beat(ACT_LOAD, r,
				(r == 0) ? diag : off, (r == 1) ? diag : off,
				(r == 2) ? diag : off, (r == 3) ? diag : off));
	endtask

	// Drop valid and wait until every owed row has come back.
	task automatic drain_rows();
		valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Port monitor: values read at the edge are the ones from before it, so a
	// beat counts when valid was high and stall low going into the edge.
	always @(posedge clk) begin : watch_ports
		row_beat_t   seen_beat;
		result_row_t seen_row;
		if (arst_n && valid && !stall) begin
			seen_beat.action  = action;
			seen_beat.row     = row_index;
			seen_beat.elem[0] = elem_0;
			seen_beat.elem[1] = elem_1;
			seen_beat.elem[2] = elem_2;
			seen_beat.elem[3] = elem_3;
			book.note_beat(seen_beat);
		end
		if (arst_n && res_valid && !res_stall) begin
			seen_row.row    = out_row;
			seen_row.col[0] = res_0;
			seen_row.col[1] = res_1;
			seen_row.col[2] = res_2;
			seen_row.col[3] = res_3;
			book.check_row(seen_row);
		end
	end

	// Result sink: per beat draw a hold, stall for it, then take one row.
	// A requested long hold replaces the draw once, so the pipe fills up.
	initial begin : result_sink
		int hold;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_long_hold > 0) begin
				hold = rx_long_hold;
				rx_long_hold = 0;
			end else
				hold = $urandom_range(0, rx_idle_max);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (valid && !stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("matrix4_row_multiply_top_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		valid        = 1'b0;
		action       = ACT_LOAD;
		row_index    = '0;
		elem_0       = '0;
		elem_1       = '0;
		elem_2       = '0;
		elem_3       = '0;
		arst_n       = 1'b0;
		tx_idle_max  = 2;
		rx_idle_max  = 2;
		rx_long_hold = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Store is zero after reset: extreme left rows must give zero rows.
		send_beat(make_beat(ACT_MUL, 3, SAT_MAX, SAT_MIN, -32'sd1, 32'sd1));
		// Identity: the left row comes back unchanged, corners included.
		load_matrix(ONE, '0);
		send_beat(make_beat(ACT_MUL, 0, SAT_MAX, SAT_MIN, -32'sd1, '0));
		send_beat(make_beat(ACT_MUL, 1, 32'sd1, -32'sd1, ONE, SAT_MIN));
		// All-max store: positive and negative clamp, and floor of a small negative.
		load_matrix(SAT_MAX, SAT_MAX);
		send_beat(make_beat(ACT_MUL, 2, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
		send_beat(make_beat(ACT_MUL, 3, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
		send_beat(make_beat(ACT_MUL, 0, -32'sd1, '0, '0, '0));
		// All-min store: the sum of min*min products exceeds 64 bits.
		load_matrix(SAT_MIN, SAT_MIN);
		send_beat(make_beat(ACT_MUL, 1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
		send_beat(make_beat(ACT_MUL, 2, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
		// Mixed store: fractions, signs, and a multiply following a load.
		load_matrix(HALF, -ONE);
		send_beat(make_beat(ACT_MUL, 3, ONE, -HALF, 32'sd3, -32'sd3));

		// Random phases with different idle mixes on both sides.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
				1: begin tx_idle_max = 19; rx_idle_max = 0;  end
				2: begin tx_idle_max = 0;  rx_idle_max = 19; end
				3: begin tx_idle_max = 19; rx_idle_max = 19; end
				4: begin tx_idle_max = 3;  rx_idle_max = 3;  end
				default: begin
					// back-to-back offers against a long receiver hold
					tx_idle_max  = 0;
					rx_idle_max  = 4;
					rx_long_hold = 150;
				end
			endcase
			repeat (200)
				send_beat(rand_beat());
			// pause the sender until every owed row is back
			if (p == 2)
				drain_rows();
		end

		drain_rows();
		repeat (12) @(posedge clk);
		if (book.errors == 0)
			$display("matrix4_row_multiply_top_tb OK");
		else
			$display("matrix4_row_multiply_top_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mrm_pkg.sv
rtl/mrm_lane.sv
rtl/mrm_merge.sv
rtl/matrix4_row_multiply_top.sv
rtl/mrm_checker.sv
test/matrix4_row_multiply_top_tb.sv
